// ----- design/ats_pkg.sv -----
// ----------------------------------------------------------------------------
// ats_pkg
// shared beat types, token kind codes and character codes of the token
// splitter
// ----------------------------------------------------------------------------
package ats_pkg;

    // token kinds
    localparam logic [1:0] KIND_SYMBOL  = 2'd0;
    localparam logic [1:0] KIND_SPECIAL = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_AT    = 8'd64;
    localparam logic [7:0] CH_NUL   = 8'd0;

    // result queue depth and count width
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QCW    = 3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       input_done;
    } t_src_beat;

    typedef struct packed {
        logic [7:0] token_char;
        logic [1:0] token_kind;
        logic       token_last;
    } t_tok_beat;

    // up to two results caused by one source beat, first one in slot 0
    typedef struct packed {
        logic      v0;
        logic      v1;
        t_tok_beat r0;
        t_tok_beat r1;
    } t_emit;

endpackage

// ----- design/ats_lexer.sv -----
// ----------------------------------------------------------------------------
// ats_lexer
// classifies one source beat against the token state and gives the results
// it causes; holds the open-symbol state
// ----------------------------------------------------------------------------
module ats_lexer #(
    parameter int unsigned SYMBOL_BUFFER_LEN = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ats_pkg::t_src_beat i_src,
    output ats_pkg::t_emit    o_emit
);
    import ats_pkg::*;

    localparam int unsigned CW = $clog2(SYMBOL_BUFFER_LEN);
    localparam logic [CW-1:0] CNT_MAX = CW'(SYMBOL_BUFFER_LEN - 1);

    logic          r_in_symbol, n_in_symbol;
    logic [7:0]    r_held, n_held;
    logic [CW-1:0] r_count, n_count;
    logic          r_swallow, n_swallow;

    logic      is_blank, is_break, is_punct, is_comma;
    logic      cls_v;
    t_tok_beat cls_r;
    t_tok_beat held_last;
    t_emit     emit;

    always_comb begin
        is_blank   = (i_src.source_byte == CH_SPACE) || (i_src.source_byte == CH_TAB);
        is_break   = (i_src.source_byte == CH_CR) || (i_src.source_byte == CH_LF);
        is_comma   = (i_src.source_byte == CH_COMMA);
        is_punct   = (i_src.source_byte == CH_HASH) || (i_src.source_byte == CH_AT)
                  || (i_src.source_byte == CH_PLUS) || (i_src.source_byte == CH_STAR)
                  || is_comma || (i_src.source_byte == CH_DOT);
        held_last  = '{token_char: r_held, token_kind: KIND_SYMBOL, token_last: 1'b1};
    end

    // result of the byte itself once no symbol is open
    always_comb begin
        cls_v = 1'b0;
        cls_r = '{token_char: i_src.source_byte, token_kind: KIND_SPECIAL, token_last: 1'b1};
        if (is_punct) begin
            cls_v = 1'b1;
        end else if (is_break) begin
            cls_v = 1'b1;
            cls_r = '{token_char: CH_LF, token_kind: KIND_NEWLINE, token_last: 1'b1};
        end
    end

    always_comb begin
        emit        = '0;
        n_in_symbol = r_in_symbol;
        n_held      = r_held;
        n_count     = r_count;
        n_swallow   = r_swallow;
        if (i_src.input_done) begin
            // close an open symbol, then the end result
            n_in_symbol = 1'b0;
            n_count     = '0;
            n_swallow   = 1'b0;
            if (r_in_symbol) begin
                emit.v0 = 1'b1;
                emit.r0 = held_last;
                emit.v1 = 1'b1;
                emit.r1 = '{token_char: CH_NUL, token_kind: KIND_END, token_last: 1'b1};
            end else begin
                emit.v0 = 1'b1;
                emit.r0 = '{token_char: CH_NUL, token_kind: KIND_END, token_last: 1'b1};
            end
        end else if (r_swallow && is_break) begin
            // line break right after a newline token is dropped
            n_swallow = 1'b0;
        end else if (r_in_symbol && !is_blank && !is_break && !is_comma) begin
            n_swallow = 1'b0;
            if (r_count < CNT_MAX) begin
                emit.v0 = 1'b1;
                emit.r0 = '{token_char: r_held, token_kind: KIND_SYMBOL, token_last: 1'b0};
                n_held  = i_src.source_byte;
                n_count = r_count + CW'(1);
            end
        end else begin
            n_swallow   = is_break;
            n_in_symbol = 1'b0;
            n_count     = '0;
            if (r_in_symbol) begin
                emit.v0 = 1'b1;
                emit.r0 = held_last;
                emit.v1 = cls_v;
                emit.r1 = cls_r;
            end else begin
                emit.v0 = cls_v;
                emit.r0 = cls_r;
            end
            if (!is_blank && !is_punct && !is_break) begin
                n_in_symbol = 1'b1;
                n_held      = i_src.source_byte;
                n_count     = CW'(1);
            end
        end
        o_emit    = emit;
        o_emit.v0 = emit.v0 && i_accept;
        o_emit.v1 = emit.v1 && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_symbol <= 1'b0;
            r_count     <= '0;
            r_swallow   <= 1'b0;
        end else if (i_accept) begin
            r_in_symbol <= n_in_symbol;
            r_count     <= n_count;
            r_swallow   <= n_swallow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

// ----- design/ats_outq.sv -----
// ----------------------------------------------------------------------------
// ats_outq
// small shifting result queue: takes up to two results a cycle; while i_out_ready is high, gives one
// ----------------------------------------------------------------------------
module ats_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ats_pkg::t_emit    i_emit,
    output logic              o_room,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ats_pkg::t_tok_beat o_out_data
);
    import ats_pkg::*;

    t_tok_beat          r_q [QDEPTH];
    t_tok_beat          n_q [QDEPTH];
    logic [QCW-1:0]     r_cnt, n_cnt;
    logic [QCW-1:0]     lvl;
    logic               pop;

    always_comb begin
        pop   = (r_cnt != '0) && i_out_ready;
        lvl   = r_cnt - QCW'(pop);
        n_cnt = lvl + QCW'(i_emit.v0) + QCW'(i_emit.v1);
        for (int k = 0; k < QDEPTH - 1; k++) begin
            n_q[k] = pop ? r_q[k+1] : r_q[k];
        end
        n_q[QDEPTH-1] = r_q[QDEPTH-1];
        for (int k = 0; k < QDEPTH; k++) begin
            if (i_emit.v0 && (lvl == QCW'(k))) begin
                n_q[k] = i_emit.r0;
            end
            if (i_emit.v1 && (lvl + QCW'(1) == QCW'(k))) begin
                n_q[k] = i_emit.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // room for two more whatever the output side does
    assign o_room      = r_cnt <= QCW'(QDEPTH - 2);
    assign o_out_valid = r_cnt != '0;
    assign o_out_data  = r_q[0];

endmodule

// ----- design/assembler_token_splitter_unit.sv -----
// path: the results of an accepted source beat are registered in the result queue
// throughput: one source beat per cycle while there is room; one result beat per
//   cycle while i_out_ready is high; a beat causing two results is absorbed by
//   a four-entry result queue that stops input only when fewer than two are free
// reset: synchronous active-low i_rst_n empties the queue and returns the
//   splitter to between-tokens; no clearing pass
// ----------------------------------------------------------------------------
// assembler_token_splitter_unit
// splits assembler source bytes into a stream of token character beats
// ----------------------------------------------------------------------------
module assembler_token_splitter_unit #(
    parameter int unsigned SYMBOL_BUFFER_LEN = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // source beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ats_pkg::t_src_beat i_in_data,
    // token beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ats_pkg::t_tok_beat o_out_data
);
    import ats_pkg::*;

    logic  accept;
    logic  room;
    t_emit emit;

    // ready depends only on queue fill, never on the output handshake
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    // classification and symbol state
    ats_lexer #(
        .SYMBOL_BUFFER_LEN (SYMBOL_BUFFER_LEN)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_src    (i_in_data),
        .o_emit   (emit)
    );

    // result register stage, one token beat leaves per cycle while i_out_ready is high
    ats_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/ats_checker.sv -----
// ----------------------------------------------------------------------------
// ats_checker
// port-level checks of the token splitter, bound to the top level
// ----------------------------------------------------------------------------
module ats_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ats_pkg::t_src_beat i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ats_pkg::t_tok_beat o_out_data
);
    import ats_pkg::*;

    // stalled token beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("token beat changed while stalled");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token beat valid after reset");

    // an accepted source beat always leaves a result visible next cycle when it ends input
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.input_done |=> o_out_valid)
        else $error("no result after end of input");

    // end and newline results are single-character tokens with fixed codes
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.token_kind == KIND_END)
        |-> o_out_data.token_last && (o_out_data.token_char == CH_NUL))
        else $error("malformed end result");

    a_nl_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.token_kind == KIND_NEWLINE)
        |-> o_out_data.token_last && (o_out_data.token_char == CH_LF))
        else $error("malformed newline result");

endmodule

bind assembler_token_splitter_unit ats_checker u_ats_checker (.*);
